### sv/assert_macros.svh
// Assertion macros used by the top level of the command packet framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cpcf_pkg.sv
// Package with the shared types and constants of the command packet framer.
`timescale 1ns / 1ps

package cpcf_pkg;

    // Packet length in bytes, and the width of a byte position counter.
    localparam int PKT_LEN = 18;
    localparam int POS_W   = $clog2(PKT_LEN);

    // One command as it travels from the front end through the queue to the serializer.
    typedef struct packed {
        logic [7:0]  command_class;
        logic [7:0]  module_index;
        logic [7:0]  sub_command;
        logic [31:0] first_parameter;
        logic [31:0] second_parameter;
        logic [15:0] response_length;
    } cmd_t;

    // Status of the serializer, watched at the top level.
    typedef struct packed {
        logic             busy;
        logic [POS_W-1:0] pos;
    } bk_status_t;

endpackage

### sv/cpcf_cmd_if.sv
// Valid/ready channel that carries one command per transfer.
`timescale 1ns / 1ps

interface cpcf_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_class;
    logic [7:0]  module_index;
    logic [7:0]  sub_command;
    logic [31:0] first_parameter;
    logic [31:0] second_parameter;
    logic [15:0] response_length;

    modport source (
        output valid,
        input  ready,
        output command_class,
        output module_index,
        output sub_command,
        output first_parameter,
        output second_parameter,
        output response_length
    );

    modport sink (
        input  valid,
        output ready,
        input  command_class,
        input  module_index,
        input  sub_command,
        input  first_parameter,
        input  second_parameter,
        input  response_length
    );
endinterface

### sv/cpcf_byte_if.sv
// Valid/ready channel that carries one packet byte per transfer.
`timescale 1ns / 1ps

interface cpcf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_of_packet;

    modport source (
        output valid,
        input  ready,
        output packet_byte,
        output last_of_packet
    );

    modport sink (
        input  valid,
        output ready,
        input  packet_byte,
        input  last_of_packet
    );
endinterface

### sv/cpcf_front.sv
// Front end: takes command transfers and registers them as packed commands.
`timescale 1ns / 1ps

module cpcf_front
    import cpcf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cpcf_cmd_if.sink      cmd,
    output logic          q_valid,
    input  logic          q_ready,
    output cmd_t          q_data
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    // The stage frees up in the same cycle that the queue takes its command.
    assign cmd.ready = !valid_reg || q_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (take)
        begin
            valid_next                = 1'b1;
            cmd_next.command_class    = cmd.command_class;
            cmd_next.module_index     = cmd.module_index;
            cmd_next.sub_command      = cmd.sub_command;
            cmd_next.first_parameter  = cmd.first_parameter;
            cmd_next.second_parameter = cmd.second_parameter;
            cmd_next.response_length  = cmd.response_length;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign q_valid = valid_reg;
    assign q_data  = cmd_reg;

endmodule

### sv/cpcf_queue.sv
// Short command queue between the front end and the serializer.
`timescale 1ns / 1ps

module cpcf_queue
    import cpcf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### sv/cpcf_back.sv
// Serializer: emits one packet byte per cycle while pkt.ready allows and builds the CRC on the way.
`timescale 1ns / 1ps

module cpcf_back
    import cpcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_data,
    cpcf_byte_if.source pkt,
    output bk_status_t  status
);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam int          CRC_SPAN = 16;

    // One byte into a CRC-16 with polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic             busy_reg;
    logic             busy_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic [7:0]       cur_byte;
    logic             advance;
    logic             last_step;
    logic             load;

    assign advance   = busy_reg && (!out_valid_reg || pkt.ready);
    assign last_step = advance && (pos_reg == POS_W'(PKT_LEN - 1));
    assign q_ready   = !busy_reg || last_step;
    assign load      = q_valid && q_ready;

    always_comb
    begin
        case (pos_reg)
            5'd0:    cur_byte = cmd_reg.command_class;
            5'd1:    cur_byte = cmd_reg.module_index;
            5'd2:    cur_byte = cmd_reg.sub_command;
            5'd4:    cur_byte = cmd_reg.first_parameter[7:0];
            5'd5:    cur_byte = cmd_reg.first_parameter[15:8];
            5'd6:    cur_byte = cmd_reg.first_parameter[23:16];
            5'd7:    cur_byte = cmd_reg.first_parameter[31:24];
            5'd8:    cur_byte = cmd_reg.second_parameter[7:0];
            5'd9:    cur_byte = cmd_reg.second_parameter[15:8];
            5'd10:   cur_byte = cmd_reg.second_parameter[23:16];
            5'd11:   cur_byte = cmd_reg.second_parameter[31:24];
            5'd12:   cur_byte = cmd_reg.response_length[7:0];
            5'd13:   cur_byte = cmd_reg.response_length[15:8];
            5'd16:   cur_byte = crc_reg[7:0];
            5'd17:   cur_byte = crc_reg[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        cmd_next  = cmd_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            crc_next  = CRC_INIT;
            cmd_next  = q_data;
        end
        else if (last_step)
        begin
            busy_next = 1'b0;
            pos_next  = '0;
        end
        else if (advance)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < POS_W'(CRC_SPAN))
            begin
                crc_next = crc_feed(crc_reg, cur_byte);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = (pos_reg == POS_W'(PKT_LEN - 1));
        end
        else if (pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign pkt.valid          = out_valid_reg;
    assign pkt.packet_byte    = out_byte_reg;
    assign pkt.last_of_packet = out_last_reg;
    assign status.busy        = busy_reg;
    assign status.pos         = pos_reg;

endmodule

### sv/command_packet_crc_framer.sv
// Top level of the command packet framer with CRC-16/XMODEM.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each command transfer on cmd becomes an 18-byte packet on pkt, one byte per
// transfer: class, module, subcommand, a zero byte, parameter one and parameter
// two least significant byte first, response length low then high, two zero
// bytes, and the CRC low then high byte, which carries last_of_packet. The CRC is
// CRC-16 with polynomial 0x1021, zero initial value, no reflection and no final
// XOR, over bytes 0 to 15. Packets follow one another without a gap as long as
// pkt.ready stays high: the serializer emits one byte per cycle while pkt.ready
// allows, and folds each of the first sixteen bytes into the CRC as it goes out.
// The front end registers a command, and a queue of QUEUE_DEPTH commands sits
// between it and the serializer, so cmd keeps taking commands while a packet is
// being sent or a finished byte waits in the output register, until they fill.
// From idle, a command passes the front register, the queue and the serializer's
// command register, and its first byte then leaves the output register.
module command_packet_crc_framer
    import cpcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    cpcf_cmd_if.sink    cmd,
    cpcf_byte_if.source pkt
);

    // Registered command out of the front end, toward the queue.
    logic       fq_valid;
    logic       fq_ready;
    cmd_t       fq_data;

    // Command out of the queue, toward the serializer.
    logic       qb_valid;
    logic       qb_ready;
    cmd_t       qb_data;

    bk_status_t bk_status;

    cpcf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    cpcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    cpcf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .pkt     (pkt),
        .status  (bk_status)
    );

    // The serializer never runs past the CRC high byte.
    `ASSERT_SAME(a_pos_in_range, clk, rst_n, bk_status.busy, bk_status.pos <= POS_W'(PKT_LEN - 1), "byte position beyond end of packet")

    // An idle serializer always waits at the first byte of a packet.
    `ASSERT_SAME(a_idle_at_start, clk, rst_n, !bk_status.busy, bk_status.pos == '0, "idle serializer not at byte zero")

    // Two packet ends never follow one another: after the last byte comes byte zero.
    `ASSERT_NEXT(a_no_double_last, clk, rst_n, pkt.valid && pkt.ready && pkt.last_of_packet, !pkt.valid || !pkt.last_of_packet, "two last bytes in a row")

endmodule

### dv/cpcf_packet_checker.sv
// Checker that predicts the framed bytes of each accepted command and compares them.
`timescale 1ns / 1ps

module cpcf_packet_checker
    import cpcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cpcf_cmd_if  cmd,
    cpcf_byte_if pkt,
    output int   fail_count,
    output int   bytes_waiting,
    output int   bytes_checked
);

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_SEED      = 16'h0000;
    localparam int          CRC_SPAN      = 16;
    localparam logic [7:0]  RESERVED_BYTE = 8'h00;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
        int         index;
    } framed_byte_t;

    framed_byte_t pending_bytes[$];
    int mismatches = 0;
    int compared   = 0;
    int waiting    = 0;

    assign fail_count    = mismatches;
    assign bytes_waiting = waiting;
    assign bytes_checked = compared;

    // One byte through the MSB-first CRC-16 register.
    function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Lays out the 18-byte packet for one command and queues its bytes.
    function automatic void frame_command(input cmd_t c);
        logic [7:0]   frame [PKT_LEN];
        logic [15:0]  crc;
        framed_byte_t entry;
        frame[0] = c.command_class;
        frame[1] = c.module_index;
        frame[2] = c.sub_command;
        frame[3] = RESERVED_BYTE;
        for (int k = 0; k < 4; k++)
        begin
            frame[4 + k] = c.first_parameter[8*k +: 8];
            frame[8 + k] = c.second_parameter[8*k +: 8];
        end
        frame[12] = c.response_length[7:0];
        frame[13] = c.response_length[15:8];
        frame[14] = RESERVED_BYTE;
        frame[15] = RESERVED_BYTE;
        crc = CRC_SEED;
        for (int k = 0; k < CRC_SPAN; k++)
            crc = crc16_xmodem_step(crc, frame[k]);
        frame[16] = crc[7:0];
        frame[17] = crc[15:8];
        for (int k = 0; k < PKT_LEN; k++)
        begin
            entry.value   = frame[k];
            entry.is_last = (k == PKT_LEN - 1);
            entry.index   = k;
            pending_bytes.push_back(entry);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        framed_byte_t want;
        cmd_t         seen;
        if (rst_n)
        begin
            if (pkt.valid && pkt.ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("packet_byte 0x%02h arrived with no byte expected",
                           pkt.packet_byte);
                    mismatches++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    compared++;
                    if (pkt.packet_byte !== want.value)
                    begin
                        $error("packet_byte (byte %0d): expected 0x%02h, actual 0x%02h",
                               want.index, want.value, pkt.packet_byte);
                        mismatches++;
                    end
                    if (pkt.last_of_packet !== want.is_last)
                    begin
                        $error("last_of_packet (byte %0d): expected %0b, actual %0b",
                               want.index, want.is_last, pkt.last_of_packet);
                        mismatches++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                seen.command_class    = cmd.command_class;
                seen.module_index     = cmd.module_index;
                seen.sub_command      = cmd.sub_command;
                seen.first_parameter  = cmd.first_parameter;
                seen.second_parameter = cmd.second_parameter;
                seen.response_length  = cmd.response_length;
                frame_command(seen);
            end
            waiting = pending_bytes.size();
        end
    end

endmodule

### dv/command_packet_crc_framer_tb.sv
// Testbench top for the command packet framer: stimulus, back-pressure, watchdog and verdict.
`timescale 1ns / 1ps

module command_packet_crc_framer_tb
    import cpcf_pkg::*;
();

    // The output hold-off is long enough to fill the front register, the command
    // queue and the serializer, so the input side is forced to stall.
    localparam int SINK_HOLD_CYCLES = 200;
    // Longest legal quiet stretch is the hold-off above plus a sender gap, so this
    // limit only trips when the block has really stopped moving.
    localparam int IDLE_LIMIT       = 1500;
    // The drain wait runs on past the last byte so that a stray extra byte is still seen.
    localparam int DRAIN_CYCLES     = 24;
    localparam int RANDOM_FIRST     = 120;
    localparam int PRESSURE_BURST   = 12;
    localparam int GAP_FREE_RUN     = 40;
    localparam int RANDOM_SECOND    = 80;
    localparam int RANDOM_LAST      = 110;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int bytes_waiting;
    int bytes_checked;
    int commands_sent = 0;

    // Handshake flags between the sender and the receiver processes. The sender
    // asks for the long hold-off; the receiver reports when it has started it.
    bit hold_request   = 1'b0;
    bit sink_holding   = 1'b0;
    bit sender_no_idle = 1'b0;

    always #5 clk = ~clk;

    cpcf_cmd_if  cmd_ch ();
    cpcf_byte_if pkt_ch ();

    command_packet_crc_framer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pkt   (pkt_ch)
    );

    cpcf_packet_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .pkt           (pkt_ch),
        .fail_count    (fail_count),
        .bytes_waiting (bytes_waiting),
        .bytes_checked (bytes_checked)
    );

    // Reset is applied once, at the start, and released on a falling edge.
    initial
    begin : reset_gen
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // The watchdog restarts its count on every transfer, on either channel.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (pkt_ch.valid && pkt_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Field values lean on zero, all ones and single set or cleared bits, since
    // those are what exposes a byte lane swap or a stuck CRC bit.
    function automatic logic [31:0] pick_field(input int width);
        logic [31:0] mask;
        logic [31:0] value;
        int          roll;
        mask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
        roll = $urandom_range(0, 9);
        case (roll)
            0:       value = '0;
            1:       value = mask;
            2:       value = 32'd1 << $urandom_range(0, width - 1);
            3:       value = ~(32'd1 << $urandom_range(0, width - 1));
            default: value = $urandom;
        endcase
        return value & mask;
    endfunction

    function automatic cmd_t make_command(input logic [7:0]  cls,
                                          input logic [7:0]  mod,
                                          input logic [7:0]  sub,
                                          input logic [31:0] p1,
                                          input logic [31:0] p2,
                                          input logic [15:0] rl);
        cmd_t c;
        c.command_class    = cls;
        c.module_index     = mod;
        c.sub_command      = sub;
        c.first_parameter  = p1;
        c.second_parameter = p2;
        c.response_length  = rl;
        return c;
    endfunction

    function automatic cmd_t random_command();
        logic [31:0] cls;
        logic [31:0] mod;
        logic [31:0] sub;
        logic [31:0] rl;
        cls = pick_field(8);
        mod = pick_field(8);
        sub = pick_field(8);
        rl  = pick_field(16);
        return make_command(cls[7:0], mod[7:0], sub[7:0],
                            pick_field(32), pick_field(32), rl[15:0]);
    endfunction

    // Mostly back-to-back or short gaps, with the odd long pause so that the
    // serializer runs dry in the middle of the stream.
    function automatic int pick_gap();
        int roll;
        if (sender_no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offers one command, holds it until the transfer, then idles for a random gap.
    // It is entered and left on a falling edge. With a zero gap, valid simply stays
    // high into the next call, so it is never lowered and raised in one time step.
    task automatic send_command(input cmd_t c);
        int gap;
        cmd_ch.valid            <= 1'b1;
        cmd_ch.command_class    <= c.command_class;
        cmd_ch.module_index     <= c.module_index;
        cmd_ch.sub_command      <= c.sub_command;
        cmd_ch.first_parameter  <= c.first_parameter;
        cmd_ch.second_parameter <= c.second_parameter;
        cmd_ch.response_length  <= c.response_length;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        @(negedge clk);
        commands_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // The sender stops offering until every predicted byte has come out.
    task automatic pause_until_drained();
        cmd_ch.valid <= 1'b0;
        wait (bytes_waiting == 0);
        @(negedge clk);
    endtask

    // Receiver: ready toggles in runs of random length. Most stalls are short,
    // some are long, and some runs stay ready for a long stretch. On request it
    // holds ready low for SINK_HOLD_CYCLES, counted here.
    initial
    begin : sink_side
        int run_left;
        int roll;
        bit ready_now;
        pkt_ch.ready = 1'b0;
        ready_now    = 1'b0;
        run_left     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !sink_holding)
            begin
                sink_holding = 1'b1;
                pkt_ch.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge clk);
                pkt_ch.ready <= 1'b1;
                ready_now    = 1'b1;
                run_left     = $urandom_range(0, 15);
                hold_request = 1'b0;
                sink_holding = 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else if (ready_now)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    pkt_ch.ready <= 1'b0;
                    ready_now    = 1'b0;
                    run_left     = $urandom_range(10, 40) - 1;
                end
                else if (roll < 70)
                begin
                    pkt_ch.ready <= 1'b0;
                    ready_now    = 1'b0;
                    run_left     = $urandom_range(1, 3) - 1;
                end
                else if (roll < 80)
                begin
                    run_left = $urandom_range(60, 120);
                end
                else
                begin
                    run_left = $urandom_range(0, 15);
                end
            end
            else
            begin
                pkt_ch.ready <= 1'b1;
                ready_now    = 1'b1;
                run_left     = $urandom_range(0, 15);
            end
        end
    end

    // Sender: directed corners first, then random phases around a forced
    // back-pressure episode and a full drain.
    initial
    begin : source_side
        cmd_ch.valid            = 1'b0;
        cmd_ch.command_class    = '0;
        cmd_ch.module_index     = '0;
        cmd_ch.sub_command      = '0;
        cmd_ch.first_parameter  = '0;
        cmd_ch.second_parameter = '0;
        cmd_ch.response_length  = '0;
        wait (rst_n === 1'b1);
        @(negedge clk);

        // Field extremes one at a time, so a misplaced byte shows up on its own,
        // plus alternating patterns and distinct bytes to catch lane swaps.
        // Every command also checks that the reserved bytes stay zero.
        send_command(make_command(8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_command(make_command(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_command(make_command(8'hFF, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_command(make_command(8'h00, 8'hFF, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_command(make_command(8'h00, 8'h00, 8'hFF, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        send_command(make_command(8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000));
        send_command(make_command(8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000));
        send_command(make_command(8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'hFFFF));
        send_command(make_command(8'h00, 8'h00, 8'h00, 32'h8000_0000, 32'h0000_0001, 16'h8000));
        send_command(make_command(8'h80, 8'h01, 8'h7F, 32'h0000_0001, 32'h8000_0000, 16'h0001));
        send_command(make_command(8'hAA, 8'hAA, 8'hAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 16'hAAAA));
        send_command(make_command(8'h55, 8'h55, 8'h55, 32'h5555_5555, 32'h5555_5555, 16'h5555));
        send_command(make_command(8'h01, 8'h02, 8'h03, 32'h0123_4567, 32'h89AB_CDEF, 16'h1234));
        send_command(make_command(8'h01, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'h0000));
        pause_until_drained();

        repeat (RANDOM_FIRST) send_command(random_command());

        // Ask the receiver for its long hold-off and keep offering commands
        // without a gap; the block must fill up and drop cmd.ready.
        cmd_ch.valid <= 1'b0;
        hold_request = 1'b1;
        wait (sink_holding);
        @(negedge clk);
        sender_no_idle = 1'b1;
        repeat (PRESSURE_BURST) send_command(random_command());
        repeat (GAP_FREE_RUN) send_command(random_command());
        sender_no_idle = 1'b0;
        repeat (RANDOM_SECOND) send_command(random_command());

        // The block goes fully idle once before the last phase.
        pause_until_drained();
        repeat (RANDOM_LAST) send_command(random_command());

        cmd_ch.valid <= 1'b0;
        wait (bytes_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Framed %0d commands: field corners, random and single-bit fields,",
                 commands_sent);
        $display("gap-free bursts, a %0d-cycle output hold-off and drains; %0d bytes compared.",
                 SINK_HOLD_CYCLES, bytes_checked);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/cpcf_pkg.sv
sv/cpcf_cmd_if.sv
sv/cpcf_byte_if.sv
sv/cpcf_front.sv
sv/cpcf_queue.sv
sv/cpcf_back.sv
sv/command_packet_crc_framer.sv
dv/cpcf_packet_checker.sv
dv/command_packet_crc_framer_tb.sv
